/* hw/rtl/ifdl_pkg.sv */
// Shared types and constants for the interpolating fractional delay line.
// No dependencies; every other file in hw/rtl imports this package.
package ifdl_pkg;

    // Store depth must be a power of two so that addresses wrap by truncation.
    localparam int DEPTH       = 2048;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int DELAY_BITS  = 27;

    localparam logic [DELAY_BITS-1:0] DELAY_RESET =
        DELAY_BITS'((DEPTH / 2) * (2 ** FRAC_BITS));
    localparam logic [DELAY_BITS-1:0] DELAY_MAX =
        DELAY_BITS'((DEPTH - 1) * (2 ** FRAC_BITS));

    typedef logic [ADDR_W-1:0]             addr_t;
    typedef logic [FRAC_BITS-1:0]          frac_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [DELAY_BITS-1:0]         delay_t;

    // The two neighboring samples that one transaction mixes.
    typedef struct packed {
        sample_t newer;
        sample_t older;
    } tap_pair_t;

endpackage

/* hw/rtl/ifdl_store.sv */
// Circular sample store: one write and two registered reads per transaction.
// Depends on ifdl_pkg. Unwritten entries read as zero through a fill flag.
module ifdl_store (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  ifdl_pkg::sample_t sample,
    input  ifdl_pkg::addr_t   whole,
    output ifdl_pkg::tap_pair_t taps
);
    import ifdl_pkg::*;

    sample_t mem [DEPTH];

    addr_t   wr_idx_reg;
    addr_t   wr_idx_next;
    logic    full_reg;
    logic    full_next;
    addr_t   addr_a;
    addr_t   addr_b;
    sample_t rd_a_reg;
    sample_t rd_b_reg;
    sample_t fwd_data_reg;
    logic    fwd_a_reg;
    logic    fwd_b_reg;
    logic    ok_a_reg;
    logic    ok_b_reg;

    assign addr_a      = wr_idx_reg - whole;
    assign addr_b      = addr_a - addr_t'(1);
    assign wr_idx_next = wr_idx_reg + addr_t'(1);
    assign full_next   = full_reg | (wr_idx_reg == addr_t'(DEPTH - 1));

    // Read happens before the write lands, so a read of the entry being
    // written this cycle is served from the forwarded sample instead.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[wr_idx_reg] <= sample;
            rd_a_reg        <= mem[addr_a];
            rd_b_reg        <= mem[addr_b];
            fwd_data_reg    <= sample;
        end
    end

    // Before the first wrap only entries at or below the write index exist.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            full_reg   <= 1'b0;
            fwd_a_reg  <= 1'b0;
            fwd_b_reg  <= 1'b0;
            ok_a_reg   <= 1'b0;
            ok_b_reg   <= 1'b0;
        end
        else if (accept)
        begin
            wr_idx_reg <= wr_idx_next;
            full_reg   <= full_next;
            fwd_a_reg  <= (addr_a == wr_idx_reg);
            fwd_b_reg  <= (addr_b == wr_idx_reg);
            ok_a_reg   <= full_reg | (addr_a <= wr_idx_reg);
            ok_b_reg   <= full_reg | (addr_b <= wr_idx_reg);
        end
    end

    always_comb
    begin
        if (fwd_a_reg)
            taps.newer = fwd_data_reg;
        else if (ok_a_reg)
            taps.newer = rd_a_reg;
        else
            taps.newer = '0;

        if (fwd_b_reg)
            taps.older = fwd_data_reg;
        else if (ok_b_reg)
            taps.older = rd_b_reg;
        else
            taps.older = '0;
    end

endmodule

/* hw/rtl/ifdl_mix.sv */
// Linear interpolation datapath: multiply stage and rounding/output stage.
// Depends on ifdl_pkg. Computes newer + (older - newer) * frac, rounded.
module ifdl_mix (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_v,
    input  ifdl_pkg::tap_pair_t taps,
    input  ifdl_pkg::frac_t     frac,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_stall,
    output ifdl_pkg::sample_t   sample_out
);
    import ifdl_pkg::*;

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
    localparam int ACC_W  = PROD_W + 1;

    logic signed [DIFF_W-1:0]    diff;
    logic signed [FRAC_BITS:0]   frac_s;
    logic signed [PROD_W-1:0]    prod;
    logic signed [PROD_W-1:0]    prod_reg;
    sample_t                     base_reg;
    logic                        p_v_reg;
    logic signed [ACC_W-1:0]     acc;
    sample_t                     out_reg;
    logic                        out_v_reg;
    logic                        out_ready;
    logic                        p_ready;

    assign out_ready = !out_v_reg || !out_stall;
    assign p_ready   = !p_v_reg || out_ready;
    assign in_ready  = p_ready;

    assign diff   = DIFF_W'(taps.older) - DIFF_W'(taps.newer);
    assign frac_s = $signed({1'b0, frac});
    assign prod   = PROD_W'(diff) * PROD_W'(frac_s);

    // The base sample sits at weight one; adding half an LSB and dropping
    // the fraction bits rounds ties toward plus infinity.
    assign acc = (ACC_W'(base_reg) <<< FRAC_BITS) + ACC_W'(prod_reg)
               + ACC_W'(1 << (FRAC_BITS - 1));

    always_ff @(posedge clk)
    begin
        if (in_v && p_ready)
        begin
            prod_reg <= prod;
            base_reg <= taps.newer;
        end
        if (p_v_reg && out_ready)
            out_reg <= acc[FRAC_BITS +: SAMPLE_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (p_ready)
                p_v_reg <= in_v;
            if (out_ready)
                out_v_reg <= p_v_reg;
        end
    end

    assign out_valid  = out_v_reg;
    assign sample_out = out_reg;

endmodule

/* hw/rtl/interpolating_fractional_delay_line.sv */
// Top level of the interpolating fractional delay line.
// Depends on ifdl_pkg, ifdl_store and ifdl_mix.
//
//   channel   signals                          direction
//   input     in_valid, in_stall, sample_in    samples in, one per transaction
//   output    out_valid, out_stall, sample_out interpolated samples out
//   config    cfg_we, delay_q16                delay register write
//
// One transaction is accepted per cycle while in_stall is low; the store
// takes one write and two reads in that cycle. The store read, the multiply
// and the rounding each take one register stage, the last driving out_valid.
// The store needs no clearing pass: entries not yet written since reset
// read as zero. in_stall follows out_stall in the same cycle once all three
// stages hold a transaction; empty stages absorb a stall first.
module interpolating_fractional_delay_line (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ifdl_pkg::sample_t sample_in,
    output logic              out_valid,
    input  logic              out_stall,
    output ifdl_pkg::sample_t sample_out,
    input  logic              cfg_we,
    input  ifdl_pkg::delay_t  delay_q16
);
    import ifdl_pkg::*;

    addr_t     whole_reg;
    addr_t     whole_next;
    frac_t     frac_reg;
    frac_t     frac_next;
    frac_t     s1_frac_reg;
    logic      s1_v_reg;
    logic      s1_ready;
    logic      mix_ready;
    logic      accept;
    tap_pair_t taps;

    // Delays beyond the last whole sample clamp to it with no fraction.
    always_comb
    begin
        if (delay_q16 > DELAY_MAX)
        begin
            whole_next = addr_t'(DEPTH - 1);
            frac_next  = '0;
        end
        else
        begin
            whole_next = delay_q16[FRAC_BITS +: ADDR_W];
            frac_next  = delay_q16[FRAC_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            whole_reg <= DELAY_RESET[FRAC_BITS +: ADDR_W];
            frac_reg  <= DELAY_RESET[FRAC_BITS-1:0];
        end
        else if (cfg_we)
        begin
            whole_reg <= whole_next;
            frac_reg  <= frac_next;
        end
    end

    assign s1_ready = !s1_v_reg || mix_ready;
    assign in_stall = !s1_ready;
    assign accept   = in_valid && s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (s1_ready)
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_frac_reg <= frac_reg;
    end

    ifdl_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sample (sample_in),
        .whole  (whole_reg),
        .taps   (taps)
    );

    ifdl_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_v       (s1_v_reg),
        .taps       (taps),
        .frac       (s1_frac_reg),
        .in_ready   (mix_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

endmodule

/* tb/sv/interpolating_fractional_delay_line_tb.sv */
// Self-checking testbench for the interpolating fractional delay line.
// Depends on ifdl_pkg and the interpolating_fractional_delay_line top level;
// predicts every output sample and compares it with what the block returns.
`timescale 1ns / 1ps

module interpolating_fractional_delay_line_tb;

    import ifdl_pkg::*;

    localparam int    IDLE_LIMIT = 2000;
    localparam int    DRAIN_WAIT = 8;
    localparam longint FRAC_ONE  = longint'(1) << FRAC_BITS;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    sample_t sample_in = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    sample_t sample_out;
    logic    cfg_we = 1'b0;
    delay_t  delay_q16 = '0;

    // Predictor state: a copy of the sample store, its write pointer and the delay.
    sample_t history [DEPTH];
    addr_t   write_ptr;
    delay_t  delay_model;

    sample_t pending_samples [$];
    sample_t expected_samples [$];
    int      queued_count = 0;
    int      accepted_count = 0;
    int      mismatches = 0;
    int      gap_pct = 0;
    int      stall_pct = 0;
    int      gap_left = 0;
    int      stall_left = 0;
    int      idle_cycles = 0;

    interpolating_fractional_delay_line u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .cfg_we     (cfg_we),
        .delay_q16  (delay_q16)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Writes one sample into the predicted store and returns the interpolated tap.
    function automatic sample_t delay_line_step(sample_t x);
        addr_t                  whole;
        addr_t                  newer_at;
        addr_t                  older_at;
        frac_t                  frac;
        logic [SAMPLE_BITS-1:0] a;
        logic [SAMPLE_BITS-1:0] b;
        logic [SAMPLE_BITS-1:0] r;
        logic [63:0]            acc;
        if (delay_model > DELAY_MAX)
        begin
            whole = addr_t'(DEPTH - 1);
            frac  = '0;
        end
        else
        begin
            whole = addr_t'(delay_model >> FRAC_BITS);
            frac  = delay_model[FRAC_BITS-1:0];
        end
        history[write_ptr] = x;
        newer_at = write_ptr - whole;
        older_at = newer_at - 1'b1;
        // Flipping the sign bit turns both samples into unsigned offset binary.
        a = {~history[newer_at][SAMPLE_BITS-1], history[newer_at][SAMPLE_BITS-2:0]};
        b = {~history[older_at][SAMPLE_BITS-1], history[older_at][SAMPLE_BITS-2:0]};
        acc = 64'(a) * (64'(FRAC_ONE) - 64'(frac)) + 64'(b) * 64'(frac)
              + 64'(FRAC_ONE / 2);
        r = acc[FRAC_BITS +: SAMPLE_BITS];
        write_ptr = write_ptr + 1'b1;
        return sample_t'({~r[SAMPLE_BITS-1], r[SAMPLE_BITS-2:0]});
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? sample_t'(16'sh7fff) : sample_t'(16'sh8000);
            1: return sample_t'($signed($urandom_range(0, 8)) - 4);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Half the delays are short so that fresh samples come back soon; the rest are long or clamped.
    function automatic delay_t pick_delay();
        case ($urandom_range(0, 5))
            0, 1: return delay_t'({$urandom_range(0, 15), 16'($urandom)});
            2:    return delay_t'({$urandom_range(0, 40), 16'h0000});
            3:    return delay_t'($urandom_range(32'(DELAY_MAX) + 1, (1 << DELAY_BITS) - 1));
            default: return delay_t'($urandom);
        endcase
    endfunction

    task automatic queue_sample(sample_t s);
        pending_samples.push_back(s);
        queued_count++;
    endtask

    task automatic wait_drained();
        while (accepted_count != queued_count || expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_delay(delay_t value);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        delay_q16 <= value;
        delay_model = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Input side: presents queued samples, holds them while stalled, inserts gaps.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_samples.push_back(delay_line_step(sample_in));
                accepted_count++;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_samples.size() != 0 && gap_pct != 0
                         && $urandom_range(0, 99) < gap_pct)
                begin
                    gap_left = $urandom_range(1, 6) - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    in_valid  <= 1'b1;
                    sample_in <= pending_samples.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: checks each transaction and stalls in random bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: sample_out expected none, got %0d", $time, sample_out);
                    mismatches++;
                end
                else if (sample_out !== expected_samples[0])
                begin
                    $display("%0t: sample_out expected %0d, got %0d",
                             $time, expected_samples[0], sample_out);
                    mismatches++;
                    void'(expected_samples.pop_front());
                end
                else
                begin
                    void'(expected_samples.pop_front());
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(1, 6) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("interpolating_fractional_delay_line: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        int phase;
        int count;
        foreach (history[i])
            history[i] = '0;
        write_ptr   = '0;
        delay_model = DELAY_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        gap_pct   = 20;
        stall_pct = 20;

        // Reset delay over a cleared store returns zeros.
        queue_sample(16'sh7fff);
        queue_sample(16'sh8000);
        queue_sample(16'sh1234);

        // Zero delay returns the sample just written.
        set_delay('0);
        queue_sample(16'sh7fff);
        queue_sample(16'sh8000);
        queue_sample(16'sh0000);
        queue_sample(-16'sd1);
        queue_sample(16'sd1);

        // Half a sample: 0 and 1 mixed lands exactly on a tie, which rounds up.
        set_delay(delay_t'(FRAC_ONE / 2));
        queue_sample(16'sd0);
        queue_sample(16'sd1);
        queue_sample(16'sh7fff);
        queue_sample(16'sh8000);
        queue_sample(-16'sd1);
        queue_sample(16'sd0);

        // Largest fraction on top of one whole sample.
        set_delay(delay_t'(2 * FRAC_ONE - 1));
        queue_sample(16'sd100);
        queue_sample(-16'sd100);
        queue_sample(16'sh7fff);
        queue_sample(16'sh8000);

        // Longest legal delay, then delays past it that must clamp.
        set_delay(DELAY_MAX);
        queue_sample(16'sh5a5a);
        queue_sample(16'sha5a5);
        set_delay(DELAY_MAX + 1'b1);
        queue_sample(16'sh7fff);
        queue_sample(16'sh8000);
        set_delay('1);
        queue_sample(16'sh0f0f);
        queue_sample(16'shf0f0);

        for (phase = 0; phase < 10; phase++)
        begin
            if (phase == 9)
                set_delay(delay_t'({$urandom_range(0, 7), 16'($urandom)}));
            else
                set_delay(pick_delay());
            case (phase % 3)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 15; stall_pct = 25; end
                default: begin gap_pct = 35; stall_pct = 10; end
            endcase
            if (phase == 9)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            count = $urandom_range(100, 130);
            repeat (count) queue_sample(pick_sample());
        end

        wait_drained();
        if (mismatches == 0)
            $display("interpolating_fractional_delay_line: match");
        else
            $display("interpolating_fractional_delay_line: mismatch");
        $finish;
    end

endmodule
